/* rtl/rpps_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rpps_pkg;

    // Neighbor table geometry.
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Metric that means no route.
    localparam logic signed [15:0] NO_ROUTE = -16'sd1000;

    // Input transaction payload.
    typedef struct packed {
        logic               mode;
        logic [15:0]        neighbor_addr;
        logic signed [15:0] advertised_metric;
        logic signed [7:0]  link_rssi;
    } cmd_t;

    // Result transaction payload.
    typedef struct packed {
        logic               parent_valid;
        logic [15:0]        parent_addr;
        logic signed [15:0] own_metric;
        logic               beacon_dropped;
    } result_t;

    // Input mode codes.
    localparam logic MODE_BEACON = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    // Datapath control word, one per microcode step.
    typedef struct packed {
        logic idx_clr;
        logic idx_inc;
        logic rd;
        logic slot_load;
        logic insert;
        logic wr_sum;
        logic cand;
        logic commit;
        logic emit;
        logic drop;
    } ctl_t;

    // Status flags from the datapath to the sequencer.
    typedef struct packed {
        logic idx_end;
        logic addr_match;
        logic full;
        logic root;
    } stat_t;

    // Branch conditions.
    typedef enum logic [2:0] {
        COND_NEXT,
        COND_JUMP,
        COND_START,
        COND_IDX_END,
        COND_NOMATCH,
        COND_FULL,
        COND_ROOT
    } cond_t;

    localparam int UPC_W = 4;
    typedef logic [UPC_W-1:0] upc_t;

    // Program addresses.
    localparam upc_t STEP_IDLE    = 4'd0;
    localparam upc_t STEP_B_LOOP  = 4'd1;
    localparam upc_t STEP_B_CMP   = 4'd2;
    localparam upc_t STEP_B_HIT   = 4'd3;
    localparam upc_t STEP_B_NEW   = 4'd4;
    localparam upc_t STEP_B_INS   = 4'd5;
    localparam upc_t STEP_B_DROP  = 4'd6;
    localparam upc_t STEP_T_START = 4'd7;
    localparam upc_t STEP_T_LOOP  = 4'd8;
    localparam upc_t STEP_T_CMP   = 4'd9;
    localparam upc_t STEP_T_FIN   = 4'd10;
    localparam upc_t STEP_DONE    = 4'd11;

    typedef struct packed {
        ctl_t  ctl;
        cond_t cond;
        upc_t  target;
    } uword_t;

    localparam ctl_t CTL_NOP = '0;

    // Microcode program.
    function automatic uword_t ucode(input upc_t pc);
        uword_t w;
        w = '{ctl: CTL_NOP, cond: COND_JUMP, target: STEP_IDLE};
        case (pc)
            STEP_IDLE:
            begin
                w.ctl.idx_clr = 1'b1;
                w.cond        = COND_START;
                w.target      = STEP_T_START;
            end
            STEP_B_LOOP:
            begin
                w.ctl.rd = 1'b1;
                w.cond   = COND_IDX_END;
                w.target = STEP_B_NEW;
            end
            STEP_B_CMP:
            begin
                w.ctl.slot_load = 1'b1;
                w.ctl.idx_inc   = 1'b1;
                w.cond          = COND_NOMATCH;
                w.target        = STEP_B_LOOP;
            end
            STEP_B_HIT:
            begin
                w.ctl.wr_sum = 1'b1;
                w.cond       = COND_JUMP;
                w.target     = STEP_DONE;
            end
            STEP_B_NEW:
            begin
                w.cond   = COND_FULL;
                w.target = STEP_B_DROP;
            end
            STEP_B_INS:
            begin
                w.ctl.insert = 1'b1;
                w.cond       = COND_JUMP;
                w.target     = STEP_B_HIT;
            end
            STEP_B_DROP:
            begin
                w.ctl.emit = 1'b1;
                w.ctl.drop = 1'b1;
                w.cond     = COND_JUMP;
                w.target   = STEP_IDLE;
            end
            STEP_T_START:
            begin
                w.cond   = COND_ROOT;
                w.target = STEP_DONE;
            end
            STEP_T_LOOP:
            begin
                w.ctl.rd = 1'b1;
                w.cond   = COND_IDX_END;
                w.target = STEP_T_FIN;
            end
            STEP_T_CMP:
            begin
                w.ctl.cand    = 1'b1;
                w.ctl.idx_inc = 1'b1;
                w.cond        = COND_JUMP;
                w.target      = STEP_T_LOOP;
            end
            STEP_T_FIN:
            begin
                w.ctl.commit = 1'b1;
                w.cond       = COND_NEXT;
            end
            STEP_DONE:
            begin
                w.ctl.emit = 1'b1;
                w.cond     = COND_JUMP;
                w.target   = STEP_IDLE;
            end
            default:
            begin
                w = '{ctl: CTL_NOP, cond: COND_JUMP, target: STEP_IDLE};
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* rtl/rpps_seq.sv */
`timescale 1ns / 1ps
`default_nettype none

module rpps_seq
    import rpps_pkg::*;
(
    input  wire   clk,
    input  wire   rst_n,
    input  wire   start,
    input  wire   mode,
    input  stat_t stat,
    output ctl_t  ctl,
    output logic  busy
);

    upc_t   pc_reg;
    upc_t   pc_next;
    uword_t word;
    logic   take;

    // Fetch the control word of the current step.
    assign word = ucode(pc_reg);
    assign ctl  = word.ctl;
    assign busy = (pc_reg != STEP_IDLE);

    // Branch resolution.
    always_comb
    begin
        pc_next = pc_reg + upc_t'(1);
        take    = 1'b0;
        unique case (word.cond)
            COND_NEXT:    take = 1'b0;
            COND_JUMP:    take = 1'b1;
            COND_IDX_END: take = stat.idx_end;
            COND_NOMATCH: take = ~stat.addr_match;
            COND_FULL:    take = stat.full;
            COND_ROOT:    take = stat.root;
            COND_START:   take = 1'b0;
            default:      take = 1'b1;
        endcase
        if (word.cond == COND_START)
        begin
            if (!start)
            begin
                pc_next = pc_reg;
            end
            else if (mode == MODE_TICK)
            begin
                pc_next = word.target;
            end
        end
        else if (take)
        begin
            pc_next = word.target;
        end
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/rpps_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module rpps_dp
    import rpps_pkg::*;
(
    input  wire     clk,
    input  wire     rst_n,
    input  wire     load,
    input  cmd_t    cmd,
    input  ctl_t    ctl,
    input  wire     cfg_we,
    input  wire     cfg_root,
    output stat_t   stat,
    output logic    done,
    output result_t result
);

    // Neighbor table.
    logic [15:0]        tab_addr [TABLE_DEPTH];
    logic signed [15:0] tab_sum  [TABLE_DEPTH];

    cmd_t               cmd_reg;
    logic [15:0]        rd_addr_reg;
    logic signed [15:0] rd_sum_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]   slot_reg;
    logic signed [15:0] best_reg;
    logic [15:0]        who_reg;
    logic               found_reg;
    logic [15:0]        parent_reg;
    logic               have_reg;
    logic signed [15:0] metric_reg;
    logic               root_reg;
    logic               done_reg;
    result_t            result_reg;

    logic signed [15:0] beacon_sum;
    logic               in_range;
    logic               better;

    assign beacon_sum = cmd_reg.advertised_metric
                        + {{8{cmd_reg.link_rssi[7]}}, cmd_reg.link_rssi};
    assign in_range   = (rd_sum_reg > NO_ROUTE) && (rd_sum_reg < 16'sd0);
    assign better     = in_range && (!found_reg || (rd_sum_reg >= best_reg));

    assign stat.idx_end    = (idx_reg == count_reg);
    assign stat.addr_match = (rd_addr_reg == cmd_reg.neighbor_addr);
    assign stat.full       = (count_reg == CNT_W'(TABLE_DEPTH));
    assign stat.root       = root_reg;

    assign done   = done_reg;
    assign result = result_reg;

    // Table writes and registered reads.
    always_ff @(posedge clk)
    begin
        if (ctl.insert)
        begin
            tab_addr[count_reg[IDX_W-1:0]] <= cmd_reg.neighbor_addr;
        end
        if (ctl.wr_sum)
        begin
            tab_sum[slot_reg] <= beacon_sum;
        end
        if (ctl.rd)
        begin
            rd_addr_reg <= tab_addr[idx_reg[IDX_W-1:0]];
            rd_sum_reg  <= tab_sum[idx_reg[IDX_W-1:0]];
        end
    end

    // Payload registers: latched command, scan candidate, result.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg <= cmd;
        end
        if (ctl.idx_clr)
        begin
            best_reg <= NO_ROUTE;
        end
        else if (ctl.cand && better)
        begin
            best_reg <= rd_sum_reg;
            who_reg  <= rd_addr_reg;
        end
        if (ctl.slot_load)
        begin
            slot_reg <= idx_reg[IDX_W-1:0];
        end
        else if (ctl.insert)
        begin
            slot_reg <= count_reg[IDX_W-1:0];
        end
        if (ctl.emit)
        begin
            result_reg.parent_valid   <= have_reg;
            result_reg.parent_addr    <= parent_reg;
            result_reg.own_metric     <= metric_reg;
            result_reg.beacon_dropped <= ctl.drop;
        end
    end

    // Control state: counters, parent, metric, root flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            count_reg  <= '0;
            found_reg  <= 1'b0;
            parent_reg <= '0;
            have_reg   <= 1'b0;
            metric_reg <= NO_ROUTE;
            root_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.emit;
            if (ctl.idx_clr)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                if (ctl.idx_inc)
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
                if (ctl.cand && better)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (ctl.insert)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (ctl.commit && found_reg)
            begin
                parent_reg <= who_reg;
                metric_reg <= best_reg;
                have_reg   <= 1'b1;
            end
            if (cfg_we)
            begin
                root_reg <= cfg_root;
                if (cfg_root)
                begin
                    metric_reg <= 16'sd0;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/rssi_path_parent_select.sv */
`timescale 1ns / 1ps
`default_nettype none

// Tree-routing parent selection by summed path RSSI.
// Commands: drive cmd and raise start; the command is taken at a clock edge
// where start is high and busy is low. mode 0 is a received beacon, which
// looks up or appends the sender in a 16-entry neighbor table and stores
// advertised_metric + link_rssi; mode 1 is a selection tick, which picks the
// neighbor with the highest sum strictly between -1000 and 0 (newest wins).
// Every command yields exactly one result on result, marked by a one-cycle
// done strobe. The receiver cannot hold results off.
// Flow: a table scan steps through the entries via one registered table
// read port. A beacon that finds its sender rewrites that entry, a new
// sender is appended behind the stored entries, and a beacon from a new
// sender on a full table is dropped and flagged in beacon_dropped. A tick
// scans every stored entry, except at the root, which skips the scan.
// busy drops in the done cycle, so the next command can be taken at the
// edge that ends it.
// Configuration: cfg_data carries is_root, written when cfg_valid and
// cfg_ready are high; cfg_ready is always high. Write only while idle.
// Reset empties the table, clears the parent and sets the metric to -1000.
module rssi_path_parent_select
    import rpps_pkg::*;
(
    input  wire     clk,
    input  wire     rst_n,
    input  wire     start,
    output logic    busy,
    input  cmd_t    cmd,
    output logic    done,
    output result_t result,
    input  wire     cfg_valid,
    output logic    cfg_ready,
    input  wire     cfg_data
);

    ctl_t  ctl;
    stat_t stat;
    logic  load;

    // A command transaction is taken only while the sequencer is idle.
    assign load      = start & ~busy;
    assign cfg_ready = 1'b1;

    rpps_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (cmd.mode),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    rpps_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .cmd      (cmd),
        .ctl      (ctl),
        .cfg_we   (cfg_valid & cfg_ready),
        .cfg_root (cfg_data),
        .stat     (stat),
        .done     (done),
        .result   (result)
    );

endmodule

`default_nettype wire
